// File: src/crc32_running_msb_first_macros.svh
// assertion macros used by the crc32r design (crc32_running_msb_first)
`ifndef CRC32_RUNNING_MSB_FIRST_MACROS_SVH
`define CRC32_RUNNING_MSB_FIRST_MACROS_SVH

// checked on every rising edge, skipped while reset is asserted
`define CRC32R_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define CRC32R_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/crc32r_pkg.sv
package crc32r_pkg;

  // widths of the remainder and of one message byte
  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  // non-reflected crc-32 generator polynomial
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C1_1DB7;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

endpackage

// File: src/crc32r_fold.sv
module crc32r_fold (
  input  crc32r_pkg::crc_t  rem_i,
  input  crc32r_pkg::byte_t byte_i,
  input  logic              clear_i,
  output crc32r_pkg::crc_t  rem_o
);

  crc32r_pkg::crc_t work;

  // restart from zero if requested, then shift one byte through the divider msb first
  always_comb begin
    work = clear_i ? '0 : rem_i;
    work = work ^ {byte_i, {(crc32r_pkg::CrcWidth - crc32r_pkg::ByteWidth){1'b0}}};
    for (int b = 0; b < crc32r_pkg::ByteWidth; b++) begin
      if (work[crc32r_pkg::CrcWidth-1]) begin
        work = {work[crc32r_pkg::CrcWidth-2:0], 1'b0} ^ crc32r_pkg::CrcPoly;
      end else begin
        work = {work[crc32r_pkg::CrcWidth-2:0], 1'b0};
      end
    end
    rem_o = work;
  end

endmodule

// File: src/crc32_running_msb_first.sv
// Running CRC-32, msb first, polynomial 0x04C11DB7, zero start, no final xor.
// One message byte per transfer on the input channel; first_byte_i restarts the
// remainder from zero, last_byte_i makes the block emit the CRC of every byte
// since the last first_byte_i (a message may span several chunks). Throughput is
// one byte per clock while the input is not stalled: the byte is registered,
// folded into the remainder by an eight-step combinational xor network, and the
// finished CRC lands in an output register. The input is stalled only while a
// last byte waits in the input register and the output register holds a result
// that has not been taken.
`include "crc32_running_msb_first_macros.svh"

module crc32_running_msb_first (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crc32r_pkg::byte_t data_byte_i,
  input  logic              first_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output crc32r_pkg::crc_t  crc_value_o
);

  logic              s1_valid_q;
  crc32r_pkg::byte_t s1_byte_q;
  logic              s1_first_q;
  logic              s1_last_q;
  crc32r_pkg::crc_t  rem_q;
  crc32r_pkg::crc_t  rem_d;
  logic              out_valid_q;
  crc32r_pkg::crc_t  out_crc_q;
  logic              out_free;
  logic              s1_adv;
  logic              in_xfer;

  // pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // byte update of the running remainder
  crc32r_fold u_fold (
    .rem_i   (rem_q),
    .byte_i  (s1_byte_q),
    .clear_i (s1_first_q),
    .rem_o   (rem_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
      s1_last_q  <= last_byte_i;
    end
  end

  // running remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (s1_adv) begin
      rem_q <= rem_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_crc_q <= rem_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  // checks
  `CRC32R_ASSERT(a_last_gives_result, s1_adv && s1_last_q |=> out_valid_q, "last byte lost")
  `CRC32R_ASSERT(a_result_matches_rem,
                 $rose(out_valid_q) |-> out_crc_q == rem_q,
                 "crc differs from remainder")
  `CRC32R_ASSERT(a_rem_holds, !s1_adv |=> $stable(rem_q), "remainder moved without a byte")
  `CRC32R_ASSERT(a_stall_cause,
                 in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q && out_stall_i,
                 "needless input stall")
  `CRC32R_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_q && !s1_valid_q, "valid during reset")

endmodule
